@@ sv/ccfp_pkg.sv @@
// shared constants, register indexes and the crc-16/modbus byte update
// for the command frame parser; no dependencies
package ccfp_pkg;

  localparam int unsigned WorkCrcSpan    = 4;
  localparam int unsigned FactoryCrcSpan = 6;
  localparam int unsigned CountW         = 4;
  localparam int unsigned CfgIndexW      = 1;
  localparam int unsigned OutDataW       = 48;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [CfgIndexW-1:0] CfgFactoryMode = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgHeaderByte  = 1'b1;

  // reflected crc-16, one byte, unrolled over its eight bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ sv/crc_checked_command_frame_parser_core.sv @@
// command frame parser: byte stream in, one checked frame result per buffer out
// depends on ccfp_pkg (constants, crc byte update)
//
// usage:
//   s_axis carries the received buffer one byte per transaction; tlast marks
//   its last byte. every byte updates the frame state (count, crc, fields) in
//   the cycle it is accepted. on the last byte a result is written to the
//   output register and shown on m_axis in the next cycle.
//   throughput is one byte per cycle: the crc update is one unrolled byte step
//   between the input and the state registers, and the output register lets a
//   new byte in while a result waits as long as m_axis_tready is high or the
//   output register is empty. a stalled result holds s_axis_tready low.
//   cfg carries register writes: index 0 factory_mode, index 1 header_byte;
//   it is always ready; the user must write it only while the block is idle,
//   which the block does not enforce. an invalid frame (short buffer, wrong
//   header, crc mismatch) returns frame_valid 0 with all fields zero. reset
//   clears the frame state, the configuration registers and the output valid.
module crc_checked_command_frame_parser_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // data_byte
  input  logic                                 s_axis_tlast,  // end_of_buffer
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // frame_valid, command, first_param, second_param, zero fill
  output logic [ccfp_pkg::OutDataW-1:0]        m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ccfp_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [7:0]                           cfg_data
);

  logic                          factory_mode;
  logic [7:0]                    header_byte;

  logic [ccfp_pkg::CountW-1:0]   byte_count, byte_count_next;
  logic [15:0]                   crc_accum, crc_accum_next;
  logic                          header_match, header_match_next;
  logic [7:0]                    cmd_hold, cmd_hold_next;
  logic [15:0]                   param_one_hold, param_one_hold_next;
  logic [15:0]                   param_two_hold, param_two_hold_next;
  logic [15:0]                   crc_received, crc_received_next;

  logic [ccfp_pkg::CountW-1:0]   span;
  logic [ccfp_pkg::CountW-1:0]   flen;
  logic                          in_acc;
  logic                          frame_ok;
  logic [40:0]                   result;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign span = factory_mode ? ccfp_pkg::CountW'(ccfp_pkg::FactoryCrcSpan)
                             : ccfp_pkg::CountW'(ccfp_pkg::WorkCrcSpan);
  assign flen = span + ccfp_pkg::CountW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      factory_mode <= 1'b0;
      header_byte  <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccfp_pkg::CfgFactoryMode: factory_mode <= cfg_data[0];
        ccfp_pkg::CfgHeaderByte:  header_byte  <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update for the byte on the input
  always_comb begin
    byte_count_next     = byte_count;
    crc_accum_next      = crc_accum;
    header_match_next   = header_match;
    cmd_hold_next       = cmd_hold;
    param_one_hold_next = param_one_hold;
    param_two_hold_next = param_two_hold;
    crc_received_next   = crc_received;
    if (byte_count < flen) begin
      if (byte_count < span) begin
        crc_accum_next = ccfp_pkg::crc_byte(crc_accum, s_axis_tdata);
      end
      priority if (byte_count == 4'd0) begin
        header_match_next = (s_axis_tdata == header_byte);
      end else if (byte_count == 4'd1) begin
        cmd_hold_next = s_axis_tdata;
      end else if (byte_count == 4'd2) begin
        param_one_hold_next[15:8] = s_axis_tdata;
      end else if (byte_count == 4'd3) begin
        param_one_hold_next[7:0] = s_axis_tdata;
      end else if (byte_count == 4'd4 && factory_mode) begin
        param_two_hold_next[15:8] = s_axis_tdata;
      end else if (byte_count == 4'd5 && factory_mode) begin
        param_two_hold_next[7:0] = s_axis_tdata;
      end else begin
      end
      if (byte_count == span) begin
        crc_received_next[7:0] = s_axis_tdata;
      end else if (byte_count == span + ccfp_pkg::CountW'(1)) begin
        crc_received_next[15:8] = s_axis_tdata;
      end
      byte_count_next = byte_count + ccfp_pkg::CountW'(1);
    end
  end

  assign frame_ok = (byte_count_next >= flen) && header_match_next
                    && (crc_accum_next == crc_received_next);

  always_comb begin
    result = '0;
    if (frame_ok) begin
      result[0]    = 1'b1;
      result[8:1]  = cmd_hold_next;
      result[24:9] = param_one_hold_next;
      if (factory_mode) begin
        result[40:25] = param_two_hold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      crc_accum      <= ccfp_pkg::CrcInit;
      header_match   <= 1'b0;
      cmd_hold       <= 8'h00;
      param_one_hold <= 16'h0000;
      param_two_hold <= 16'h0000;
      crc_received   <= 16'h0000;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        byte_count     <= '0;
        crc_accum      <= ccfp_pkg::CrcInit;
        header_match   <= 1'b0;
        cmd_hold       <= 8'h00;
        param_one_hold <= 16'h0000;
        param_two_hold <= 16'h0000;
        crc_received   <= 16'h0000;
      end else begin
        byte_count     <= byte_count_next;
        crc_accum      <= crc_accum_next;
        header_match   <= header_match_next;
        cmd_hold       <= cmd_hold_next;
        param_one_hold <= param_one_hold_next;
        param_two_hold <= param_two_hold_next;
        crc_received   <= crc_received_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tlast) begin
      m_axis_tdata <= {{(ccfp_pkg::OutDataW - 41){1'b0}}, result};
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= ccfp_pkg::CountW'(ccfp_pkg::FactoryCrcSpan + 2))
    else $error("byte count past the longest frame");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |=> byte_count == '0 && crc_accum == ccfp_pkg::CrcInit
                               && !header_match)
    else $error("frame state not cleared after the last byte");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after the last byte");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[40:1] == '0)
    else $error("invalid result carries nonzero fields");

  a_work_no_second: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast && !factory_mode |=> m_axis_tdata[40:25] == 16'h0000)
    else $error("second parameter set in work mode");
`endif

endmodule

@@ sim/crc_checked_command_frame_parser_core_tb.sv @@
// self-checking bench for crc_checked_command_frame_parser_core: byte buffers in, frame checks out
// predicts results from its own crc-16/modbus tracker or typed rows; depends on ccfp_pkg
`timescale 1ns / 100ps

module crc_checked_command_frame_parser_core_tb;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseBytes   = 105;
  localparam int unsigned RowCount     = 26;

  typedef struct packed {
    logic [15:0] second_param;
    logic [15:0] first_param;
    logic [7:0]  command;
    logic        frame_valid;
  } frame_result_t;

  typedef enum logic [1:0] {RowRaw, RowCrcLo, RowCrcHi, RowCrcLoBad} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [7:0]    data;
    logic          last;
    logic          typed;
    frame_result_t result;
  } stim_row_t;

  localparam frame_result_t NoFrame   = '0;
  localparam frame_result_t OnesFrame = '{second_param: 16'h0000, first_param: 16'hFFFF,
                                          command: 8'hFF, frame_valid: 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ccfp_pkg::OutDataW-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ccfp_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  crc_checked_command_frame_parser_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // configuration copy and frame tracker state
  logic        cfg_factory = 1'b0;
  logic [7:0]  cfg_header = 8'h00;
  logic [3:0]  trk_count = '0;
  logic [15:0] trk_crc = ccfp_pkg::CrcInit;
  logic        trk_header_ok = 1'b0;
  logic [7:0]  trk_command = '0;
  logic [15:0] trk_param_one = '0;
  logic [15:0] trk_param_two = '0;
  logic [15:0] trk_crc_rx = '0;

  frame_result_t pending_frames[$];
  frame_result_t want_frame;
  frame_result_t got_frame;
  stim_row_t     directed_rows [RowCount];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned good_frames = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  int unsigned cycles = 0;
  int unsigned rx_stall;
  bit          no_idle = 1'b0;

  assign got_frame = frame_result_t'(m_axis_tdata[$bits(frame_result_t)-1:0]);

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ ccfp_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic bit predict_frame_check(input logic [7:0] b, input logic last,
                                             output frame_result_t res);
    int unsigned span;
    int unsigned flen;
    int unsigned pos;
    bit ok;
    span = cfg_factory ? ccfp_pkg::FactoryCrcSpan : ccfp_pkg::WorkCrcSpan;
    flen = span + 2;
    pos = trk_count;
    res = NoFrame;
    if (pos < flen) begin
      if (pos < span) trk_crc = crc16_update(trk_crc, b);
      case (pos)
        0: trk_header_ok = (b == cfg_header);
        1: trk_command = b;
        2: trk_param_one[15:8] = b;
        3: trk_param_one[7:0] = b;
        4: if (span > 4) trk_param_two[15:8] = b;
        5: if (span > 5) trk_param_two[7:0] = b;
        default: ;
      endcase
      if (pos == span) trk_crc_rx[7:0] = b;
      else if (pos == span + 1) trk_crc_rx[15:8] = b;
      trk_count = 4'(pos + 1);
    end
    if (!last) return 1'b0;
    ok = (trk_count >= flen) && trk_header_ok && (trk_crc == trk_crc_rx);
    if (ok) begin
      res.frame_valid = 1'b1;
      res.command = trk_command;
      res.first_param = trk_param_one;
      res.second_param = cfg_factory ? trk_param_two : 16'h0000;
    end
    trk_count = '0;
    trk_crc = ccfp_pkg::CrcInit;
    trk_header_ok = 1'b0;
    trk_command = '0;
    trk_param_one = '0;
    trk_param_two = '0;
    trk_crc_rx = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last, input logic use_typed,
                           input frame_result_t typed);
    int unsigned gap;
    frame_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (last) buffers_sent++;
    if (predict_frame_check(data, last, res)) pending_frames.push_back(use_typed ? typed : res);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic write_settings(input logic mode, input logic [7:0] hdr);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ccfp_pkg::CfgFactoryMode;
    cfg_data <= {7'b0, mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_factory = mode;
    cfg_index <= ccfp_pkg::CfgHeaderByte;
    cfg_data <= hdr;
    do @(posedge clk); while (!cfg_ready);
    cfg_header = hdr;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_buffer();
    int unsigned kind;
    int unsigned span;
    int unsigned len;
    logic [15:0] crc;
    logic [7:0] frame_bytes[$];
    kind = $urandom_range(0, 99);
    span = cfg_factory ? ccfp_pkg::FactoryCrcSpan : ccfp_pkg::WorkCrcSpan;
    if (kind >= 95) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(pick_byte());
    end else begin
      if (kind >= 70 && kind < 80) frame_bytes.push_back(cfg_header ^ 8'($urandom_range(1, 255)));
      else frame_bytes.push_back(cfg_header);
      repeat (span - 1) frame_bytes.push_back(pick_byte());
      crc = ccfp_pkg::CrcInit;
      foreach (frame_bytes[i]) crc = crc16_update(crc, frame_bytes[i]);
      if (kind >= 80 && kind < 90) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      if (kind >= 90) begin
        len = $urandom_range(1, span + 1);
        while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(pick_byte());
      end
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NoFrame);
    end
  endtask

  // result side: random stall before each transaction, none while no_idle is set
  initial begin
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      rx_stall = no_idle ? 0 : $urandom_range(0, 3);
      if (rx_stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t ns: result with nothing pending, expected none got %h",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want_frame = pending_frames.pop_front();
        check_field("frame_valid", 16'(want_frame.frame_valid), 16'(got_frame.frame_valid));
        check_field("command", 16'(want_frame.command), 16'(got_frame.command));
        check_field("first_param", want_frame.first_param, got_frame.first_param);
        check_field("second_param", want_frame.second_param, got_frame.second_param);
        results_seen++;
        if (got_frame.frame_valid) good_frames++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("crc_checked_command_frame_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic [15:0] tx_crc;
    logic [7:0] byte_val;
    logic phase_mode;
    logic [7:0] phase_header;
    int unsigned phase_start;
    bit paused;

    directed_rows = '{
      // short buffer
      '{RowRaw, 8'h00, 1'b1, 1'b1, NoFrame},
      // good work frame, all-ones fields
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'hFF, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'hFF, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'hFF, 1'b0, 1'b0, NoFrame},
      '{RowCrcLo, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowCrcHi, 8'h00, 1'b1, 1'b1, OnesFrame},
      // wrong header
      '{RowRaw, 8'h01, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowCrcLo, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowCrcHi, 8'h00, 1'b1, 1'b1, NoFrame},
      // crc mismatch
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h5A, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h12, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h34, 1'b0, 1'b0, NoFrame},
      '{RowCrcLoBad, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowCrcHi, 8'h00, 1'b1, 1'b1, NoFrame},
      // good frame with a trailing byte
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h80, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'h01, 1'b0, 1'b0, NoFrame},
      '{RowCrcLo, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowCrcHi, 8'h00, 1'b0, 1'b0, NoFrame},
      '{RowRaw, 8'hFF, 1'b1, 1'b0, NoFrame}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_crc = ccfp_pkg::CrcInit;
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      case (row.kind)
        RowCrcLo: byte_val = tx_crc[7:0];
        RowCrcLoBad: byte_val = ~tx_crc[7:0];
        RowCrcHi: byte_val = tx_crc[15:8];
        default: begin
          byte_val = row.data;
          tx_crc = crc16_update(tx_crc, row.data);
        end
      endcase
      send_byte(byte_val, row.last, row.typed, row.result);
      if (row.last) tx_crc = ccfp_pkg::CrcInit;
    end

    paused = 1'b0;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin phase_mode = 1'b1; phase_header = 8'hFF; end
        1: begin phase_mode = 1'b0; phase_header = 8'h00; end
        2: begin phase_mode = 1'b1; phase_header = 8'h00; end
        3: begin phase_mode = 1'b0; phase_header = 8'hFF; end
        default: begin
          phase_mode = 1'($urandom_range(0, 1));
          phase_header = 8'($urandom);
        end
      endcase
      write_settings(phase_mode, phase_header);
      no_idle = (p == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        send_random_buffer();
        if (!paused && bytes_sent - phase_start > PhaseBytes / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d bytes in %0d buffers over %0d settings, both frame modes",
             bytes_sent, buffers_sent, PhaseCount + 1);
    $display("checked %0d results, %0d of them good frames", results_seen, good_frames);
    if (mismatches == 0) begin
      $display("crc_checked_command_frame_parser_core: match");
    end else begin
      $display("crc_checked_command_frame_parser_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ccfp_pkg.sv
sv/crc_checked_command_frame_parser_core.sv
sim/crc_checked_command_frame_parser_core_tb.sv
